// ----- rtl/core/sp2c_pkg.sv -----
`timescale 1ns / 1ps
// sp2c_pkg: field widths, fixed-point constants, register codes and the
// sideband struct shared by the scan polar-to-cartesian modules. no dependencies.
package sp2c_pkg;

   // field widths
   localparam int BEAM_W     = 12;
   localparam int RANGE_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int POINT_W    = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // beam index is reduced modulo the scan length, a power of two
   localparam int unsigned MAX_BEAMS = 4096;
   localparam int IDX_W = $clog2(MAX_BEAMS);

   // fixed-point formats
   localparam int FRAC_W = 30;                 // q30 magnitude below one
   localparam int T_W    = FRAC_W + 1;         // q30 value up to and including one
   localparam int TRIG_W = 17;                 // q16 value up to and including one
   localparam int PI_W   = 34;
   localparam int XSH    = 17;
   localparam int RND_SH = FRAC_W - 16;

   localparam logic [PI_W-1:0] PI_Q32  = 34'd13493037705;
   localparam logic [T_W-1:0]  ONE_Q30 = 31'h4000_0000;
   localparam logic [13:0]     OCTANT  = 14'd8192;
   localparam logic [14:0]     QUARTER = 15'd16384;

   // polynomial cell chains
   localparam int COS_CELLS = 5;
   localparam int SIN_CELLS = 4;
   localparam int CELL_LAT  = 2;
   localparam int LINE_LEN  = CELL_LAT * COS_CELLS;
   localparam int SIN_OFS   = CELL_LAT * (COS_CELLS - SIN_CELLS);
   localparam int unsigned COS_DIV [COS_CELLS] = '{90, 56, 30, 12, 2};
   localparam int unsigned SIN_DIV [SIN_CELLS] = '{72, 42, 20, 6};

   // quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP  = 2'd1;

   // most negative code of a point field, never produced
   localparam logic [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

   // per-item data that rides alongside the cell chains
   typedef struct packed {
      logic [RANGE_W-1:0] range_val;
      logic [1:0]         quad;
      logic               swap;
      logic [FRAC_W-1:0]  x;
      logic [FRAC_W-1:0]  x2;
   } sp2c_side_type;

endpackage

// ----- rtl/core/sp2c_intf.sv -----
`timescale 1ns / 1ps
// sp2c channel interfaces: sample request, point response and register write.
// depends on sp2c_pkg for the field widths.
interface sp2c_req_if import sp2c_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BEAM_W-1:0]  beam_index;
   logic [RANGE_W-1:0] range_sample;

   modport source (output valid, output beam_index, output range_sample, input ready);
   modport sink   (input valid, input beam_index, input range_sample, output ready);
endinterface

interface sp2c_rsp_if import sp2c_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface sp2c_csr_if import sp2c_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sp2c_front.sv -----
`timescale 1ns / 1ps
// sp2c_front: beam angle, octant fold, angle in radians and its square.
// three register stages; depends on sp2c_pkg.
module sp2c_front import sp2c_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               take,
   input  logic [BEAM_W-1:0]  beam_index,
   input  logic [RANGE_W-1:0] range_sample,
   input  logic [ANGLE_W-1:0] start_angle,
   input  logic [ANGLE_W-1:0] angle_step,
   output logic               vld_out,
   output sp2c_side_type      side_out
);

   localparam int PROD_W = IDX_W + ANGLE_W;
   localparam int XP_W   = 14 + PI_W;

   // stage 0: beam angle
   logic                vld0_ff;
   logic [ANGLE_W-1:0]  ang_ff;
   logic [ANGLE_W-1:0]  ang_in;
   logic [RANGE_W-1:0]  rng0_ff;
   logic [PROD_W-1:0]   idx_step;

   assign idx_step = PROD_W'(beam_index[IDX_W-1:0]) * PROD_W'(angle_step);
   assign ang_in   = start_angle + idx_step[ANGLE_W-1:0];

   // stage 1: fold into the first octant, scale to radians
   logic                vld1_ff;
   logic [FRAC_W-1:0]   x_ff;
   logic [FRAC_W-1:0]   x_in;
   logic [1:0]          quad1_ff;
   logic                swap1_ff;
   logic                swap_in;
   logic [RANGE_W-1:0]  rng1_ff;
   logic [13:0]         rem;
   logic [13:0]         folded;
   logic [XP_W-1:0]     x_prod;

   assign rem     = ang_ff[13:0];
   assign swap_in = rem > OCTANT;
   assign folded  = swap_in ? 14'(QUARTER - {1'b0, rem}) : rem;
   assign x_prod  = XP_W'(folded) * XP_W'(PI_Q32);
   assign x_in    = x_prod[FRAC_W+XSH-1:XSH];

   // stage 2: square of the angle
   logic                vld2_ff;
   sp2c_side_type       side2_ff;
   logic [2*FRAC_W-1:0] x2_prod;

   assign x2_prod = (2*FRAC_W)'(x_ff) * (2*FRAC_W)'(x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= take;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff             <= ang_in;
         rng0_ff            <= range_sample;
         x_ff               <= x_in;
         quad1_ff           <= ang_ff[15:14];
         swap1_ff           <= swap_in;
         rng1_ff            <= rng0_ff;
         side2_ff.range_val <= rng1_ff;
         side2_ff.quad      <= quad1_ff;
         side2_ff.swap      <= swap1_ff;
         side2_ff.x         <= x_ff;
         side2_ff.x2        <= x2_prod[2*FRAC_W-1:FRAC_W];
      end
   end

   assign vld_out  = vld2_ff;
   assign side_out = side2_ff;

endmodule

// ----- rtl/core/sp2c_cell.sv -----
`timescale 1ns / 1ps
// sp2c_cell: one horner step t = 1 - (x2 * t_prev) / DIV in q30, two stages.
// the division is a reciprocal multiply exact for 30-bit operands; uses sp2c_pkg.
module sp2c_cell import sp2c_pkg::*; #(
   parameter int unsigned DIV = 2
) (
   input  logic              clock,
   input  logic              en,
   input  logic [FRAC_W-1:0] x2,
   input  logic [T_W-1:0]    t_prev,
   output logic [T_W-1:0]    t_out
);

   localparam int          L     = $clog2(DIV);
   localparam int          SH    = FRAC_W + L;
   localparam logic [63:0] M64   = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam logic [31:0] RECIP = M64[31:0];
   localparam int          VP_W  = FRAC_W + T_W;
   localparam int          QP_W  = SH + FRAC_W;

   logic [FRAC_W-1:0] v_ff;
   logic [VP_W-1:0]   v_prod;
   logic [T_W-1:0]    t_ff;
   logic [T_W-1:0]    t_in;
   logic [QP_W-1:0]   q_prod;

   assign v_prod = VP_W'(x2) * VP_W'(t_prev);
   assign q_prod = QP_W'(v_ff) * QP_W'(RECIP);
   assign t_in   = ONE_Q30 - T_W'(q_prod[QP_W-1:SH]);

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_prod[2*FRAC_W-1:FRAC_W];
         t_ff <= t_in;
      end
   end

   assign t_out = t_ff;

endmodule

// ----- rtl/core/sp2c_back.sv -----
`timescale 1ns / 1ps
// sp2c_back: final sine product, q16 rounding, octant and quadrant mapping,
// range scaling and the output register; depends on sp2c_pkg.
module sp2c_back import sp2c_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      vld_in,
   input  sp2c_side_type             side,
   input  logic [T_W-1:0]            sin_t,
   input  logic [T_W-1:0]            cos_q30,
   input  logic                      rsp_ready,
   output logic                      hold_vld,
   output logic                      rsp_valid,
   output logic signed [POINT_W-1:0] point_x,
   output logic signed [POINT_W-1:0] point_y
);

   localparam int SP_W = FRAC_W + T_W;
   localparam int SC_W = RANGE_W + TRIG_W + 1;

   // stage 1: sine = x * t
   logic               b1_vld_ff;
   logic [RANGE_W-1:0] rng1_ff;
   logic [1:0]         quad1_ff;
   logic               swap1_ff;
   logic [FRAC_W-1:0]  s_ff;
   logic [T_W-1:0]     c_ff;
   logic [SP_W-1:0]    s_prod;

   assign s_prod = SP_W'(side.x) * SP_W'(sin_t);

   // stage 2: rounding and sign mapping
   logic               b2_vld_ff;
   logic [RANGE_W-1:0] rng2_ff;
   logic [TRIG_W-1:0]  xm_ff;
   logic [TRIG_W-1:0]  ym_ff;
   logic [TRIG_W-1:0]  xm_in;
   logic [TRIG_W-1:0]  ym_in;
   logic               xn_ff;
   logic               yn_ff;
   logic               xn_in;
   logic               yn_in;
   logic [T_W-1:0]     s_sum;
   logic [T_W:0]       c_sum;
   logic [TRIG_W-1:0]  s16;
   logic [TRIG_W-1:0]  c16;
   logic [TRIG_W-1:0]  sv;
   logic [TRIG_W-1:0]  cv;

   assign s_sum = T_W'(s_ff) + (T_W'(1) << (RND_SH - 1));
   assign c_sum = (T_W + 1)'(c_ff) + ((T_W + 1)'(1) << (RND_SH - 1));
   assign s16   = s_sum[RND_SH+TRIG_W-1:RND_SH];
   assign c16   = c_sum[RND_SH+TRIG_W-1:RND_SH];
   // upper octant: sine and cosine trade places
   assign sv    = swap1_ff ? c16 : s16;
   assign cv    = swap1_ff ? s16 : c16;

   always_comb begin
      case (quad1_ff)
         QUAD_0: begin
            xm_in = cv; xn_in = 1'b0; ym_in = sv; yn_in = 1'b0;
         end
         QUAD_1: begin
            xm_in = sv; xn_in = 1'b1; ym_in = cv; yn_in = 1'b0;
         end
         QUAD_2: begin
            xm_in = cv; xn_in = 1'b1; ym_in = sv; yn_in = 1'b1;
         end
         default: begin
            xm_in = sv; xn_in = 1'b0; ym_in = cv; yn_in = 1'b1;
         end
      endcase
   end

   // output stage: range scaling, round half away from zero
   logic                      out_vld_ff;
   logic signed [POINT_W-1:0] px_ff;
   logic signed [POINT_W-1:0] py_ff;
   logic [POINT_W-1:0]        px_in;
   logic [POINT_W-1:0]        py_in;
   logic [SC_W-1:0]           x_sc;
   logic [SC_W-1:0]           y_sc;
   logic [POINT_W-1:0]        xmag;
   logic [POINT_W-1:0]        ymag;
   logic                      load;

   assign x_sc  = SC_W'(rng2_ff) * SC_W'(xm_ff) + (SC_W'(1) << 15);
   assign y_sc  = SC_W'(rng2_ff) * SC_W'(ym_ff) + (SC_W'(1) << 15);
   assign xmag  = x_sc[POINT_W+15:16];
   assign ymag  = y_sc[POINT_W+15:16];
   assign px_in = xn_ff ? (POINT_W'(0) - xmag) : xmag;
   assign py_in = yn_ff ? (POINT_W'(0) - ymag) : ymag;
   assign load  = en && b2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            b1_vld_ff <= vld_in;
            b2_vld_ff <= b1_vld_ff;
         end
         if (load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rng1_ff  <= side.range_val;
         quad1_ff <= side.quad;
         swap1_ff <= side.swap;
         s_ff     <= s_prod[2*FRAC_W-1:FRAC_W];
         c_ff     <= cos_q30;
         rng2_ff  <= rng1_ff;
         xm_ff    <= xm_in;
         ym_ff    <= ym_in;
         xn_ff    <= xn_in;
         yn_ff    <= yn_in;
      end
      if (load) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign hold_vld  = b2_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign point_x   = px_ff;
   assign point_y   = py_ff;

endmodule

// ----- rtl/core/scan_polar_to_cartesian.sv -----
`timescale 1ns / 1ps
// scan_polar_to_cartesian: top level of the laser scan point converter.
// depends on sp2c_pkg, sp2c_intf, sp2c_front, sp2c_cell and sp2c_back.
//
// usage
//  - csr_chan writes start_angle (index 0) and angle_step (index 1), 16-bit
//    binary angle units; other indexes are ignored. csr ready is always high,
//    write only while no sample is in flight
//  - req_chan carries one beam (beam_index, range_sample) per transfer; one
//    rsp_chan transfer (point_x, point_y) comes back for each, in order
//  - pipeline: a req transfer passes 3 front stages, 5 horner cells of 2
//    stages each for cosine with the 4 sine cells alongside, 2 back stages
//    and the output register before the result is valid
//  - throughput: one sample per cycle unless stalled, set by the cell chains; a
//    new transfer is taken while a finished point waits in the output register
//  - stall: only when the output register is still held and the last internal
//    stage also carries a finished point does the whole pipe freeze and
//    req_chan.ready drop; empty stages are not squeezed out
//  - reset: synchronous, clears both angle registers and all valid bits; no
//    stored tables, so the block is ready in the cycle after reset
module scan_polar_to_cartesian import sp2c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sp2c_req_if.sink    req_chan,
   sp2c_rsp_if.source  rsp_chan,
   sp2c_csr_if.sink    csr_chan
);

   // angle registers
   logic [ANGLE_W-1:0] start_angle_ff;
   logic [ANGLE_W-1:0] angle_step_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_START_ANGLE: start_angle_ff <= csr_chan.data[ANGLE_W-1:0];
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_chan.data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: freeze only when a finished point has nowhere to go
   logic en;
   logic hold_vld;

   assign en             = !(hold_vld && rsp_chan.valid && !rsp_chan.ready);
   assign req_chan.ready = en;

   // front: angle, fold, radians, square
   logic          front_vld;
   sp2c_side_type front_side;

   sp2c_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .take         (req_chan.valid && req_chan.ready),
      .beam_index   (req_chan.beam_index),
      .range_sample (req_chan.range_sample),
      .start_angle  (start_angle_ff),
      .angle_step   (angle_step_ff),
      .vld_out      (front_vld),
      .side_out     (front_side)
   );

   // sideband delay line: tap k lines up with the item entering cell stage k
   sp2c_side_type       side_tap [LINE_LEN+1];
   logic [LINE_LEN:0]   vld_tap;
   sp2c_side_type       side_ff  [LINE_LEN];
   logic [LINE_LEN-1:0] vld_ff;

   assign side_tap[0] = front_side;
   assign vld_tap[0]  = front_vld;

   for (genvar i = 0; i < LINE_LEN; i++) begin : g_tap
      assign side_tap[i+1] = side_ff[i];
      assign vld_tap[i+1]  = vld_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_tap[LINE_LEN-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            side_ff[i] <= side_tap[i];
         end
      end
   end

   // cosine chain: 1 - x2/2 (1 - x2/12 (1 - x2/30 (1 - x2/56 (1 - x2/90))))
   logic [T_W-1:0] cos_t [COS_CELLS+1];

   assign cos_t[0] = ONE_Q30;

   for (genvar k = 0; k < COS_CELLS; k++) begin : g_cos
      sp2c_cell #(
         .DIV (COS_DIV[k])
      ) u_cell (
         .clock  (clock),
         .en     (en),
         .x2     (side_tap[CELL_LAT*k].x2),
         .t_prev (cos_t[k]),
         .t_out  (cos_t[k+1])
      );
   end

   // sine chain, entered later so both chains finish together;
   // the final multiply by x happens in the back end
   logic [T_W-1:0] sin_t [SIN_CELLS+1];

   assign sin_t[0] = ONE_Q30;

   for (genvar j = 0; j < SIN_CELLS; j++) begin : g_sin
      sp2c_cell #(
         .DIV (SIN_DIV[j])
      ) u_cell (
         .clock  (clock),
         .en     (en),
         .x2     (side_tap[SIN_OFS+CELL_LAT*j].x2),
         .t_prev (sin_t[j]),
         .t_out  (sin_t[j+1])
      );
   end

   // back end and output register
   sp2c_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_in    (vld_tap[LINE_LEN]),
      .side      (side_tap[LINE_LEN]),
      .sin_t     (sin_t[SIN_CELLS]),
      .cos_q30   (cos_t[COS_CELLS]),
      .rsp_ready (rsp_chan.ready),
      .hold_vld  (hold_vld),
      .rsp_valid (rsp_chan.valid),
      .point_x   (rsp_chan.point_x),
      .point_y   (rsp_chan.point_y)
   );

   // a finished point behind a held output is kept, not dropped
   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      (hold_vld && rsp_chan.valid && !rsp_chan.ready) |=> hold_vld)
      else $error("finished point lost while output stalled");

   // magnitudes never exceed the range, so the most negative code cannot appear
   a_point_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.point_x != POINT_MIN && rsp_chan.point_y != POINT_MIN))
      else $error("point coordinate out of range");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule

// ----- tb/scan_polar_to_cartesian_tb.sv -----
`timescale 1ns / 1ps
// scan_polar_to_cartesian_tb: self-checking bench for the scan point converter.
// depends on sp2c_pkg, the sp2c channel interfaces and scan_polar_to_cartesian.
module scan_polar_to_cartesian_tb;
   import sp2c_pkg::*;

   // pipe depth from req transfer to rsp valid when the receiver keeps up
   localparam int PIPE_LATENCY    = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SCAN_PHASES     = 8;
   localparam int BEAMS_PER_PHASE = 105;
   localparam int MAX_REPORTS     = 100;

   // register indexes the block has no register behind
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef bit [63:0] u64;

   typedef struct packed {
      logic signed [POINT_W-1:0] x;
      logic signed [POINT_W-1:0] y;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sp2c_req_if req_if ();
   sp2c_rsp_if rsp_if ();
   sp2c_csr_if csr_if ();

   scan_polar_to_cartesian uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #1 clock = ~clock;

   // bench copy of the two angle registers
   logic [ANGLE_W-1:0] start_angle_q;
   logic [ANGLE_W-1:0] angle_step_q;

   // points still owed by the block, oldest first
   point_type expected_points [$];

   int  mismatch_count  = 0;
   int  samples_sent    = 0;
   int  points_checked  = 0;
   int  register_writes = 0;
   int  cycle_count     = 0;
   bit  sender_steady   = 1'b0;
   bit  receiver_steady = 1'b0;

   // ---------------------------------------------------------------
   // point predictor
   // ---------------------------------------------------------------

   // q30 product, truncated
   function automatic u64 mul_q30(input u64 a, input u64 b);
      return (a * b) >> FRAC_W;
   endfunction

   // sine and cosine in q16 of an angle within the first octant (0..8192)
   function automatic void octant_sin_cos(input u64 r, output u64 sin_q16,
                                          output u64 cos_q16);
      u64 x;
      u64 x2;
      u64 t;
      u64 s;
      u64 c;
      x  = (r * PI_Q32) >> XSH;
      x2 = mul_q30(x, x);

      // horner form of the taylor series, each step truncating
      t = ONE_Q30 - x2 / 72;
      t = ONE_Q30 - mul_q30(x2, t) / 42;
      t = ONE_Q30 - mul_q30(x2, t) / 20;
      t = ONE_Q30 - mul_q30(x2, t) / 6;
      s = mul_q30(x, t);

      t = ONE_Q30 - x2 / 90;
      t = ONE_Q30 - mul_q30(x2, t) / 56;
      t = ONE_Q30 - mul_q30(x2, t) / 30;
      t = ONE_Q30 - mul_q30(x2, t) / 12;
      c = ONE_Q30 - mul_q30(x2, t) / 2;

      // q30 down to q16, round half up
      sin_q16 = (s + (u64'(1) << (RND_SH - 1))) >> RND_SH;
      cos_q16 = (c + (u64'(1) << (RND_SH - 1))) >> RND_SH;
   endfunction

   // range times a trig magnitude, halves away from zero, then the sign
   function automatic logic [POINT_W-1:0] scale_by_trig(input u64 range_val,
                                                        input u64 mag, input bit neg);
      u64 p;
      logic [POINT_W-1:0] v;
      p = (range_val * mag + 32768) >> 16;
      v = p[POINT_W-1:0];
      return neg ? (~v + 1'b1) : v;
   endfunction

   function automatic point_type predict_point(input logic [BEAM_W-1:0] beam,
                                               input logic [RANGE_W-1:0] range_val);
      logic [ANGLE_W-1:0] ang;
      logic [1:0]         quad;
      logic [13:0]        rem;
      u64                 s;
      u64                 c;
      point_type          p;
      // angle wraps modulo a full turn by truncation to 16 bits
      ang  = start_angle_q + ANGLE_W'(beam) * angle_step_q;
      quad = ang[15:14];
      rem  = ang[13:0];
      // past the octant: fold back and swap sine with cosine
      if (rem > OCTANT) begin
         octant_sin_cos(QUARTER - rem, c, s);
      end else begin
         octant_sin_cos(rem, s, c);
      end
      case (quad)
         QUAD_0: begin
            p.x = scale_by_trig(range_val, c, 1'b0);
            p.y = scale_by_trig(range_val, s, 1'b0);
         end
         QUAD_1: begin
            p.x = scale_by_trig(range_val, s, 1'b1);
            p.y = scale_by_trig(range_val, c, 1'b0);
         end
         QUAD_2: begin
            p.x = scale_by_trig(range_val, c, 1'b1);
            p.y = scale_by_trig(range_val, s, 1'b1);
         end
         default: begin
            p.x = scale_by_trig(range_val, s, 1'b0);
            p.y = scale_by_trig(range_val, c, 1'b1);
         end
      endcase
      return p;
   endfunction

   // ---------------------------------------------------------------
   // random shaping
   // ---------------------------------------------------------------

   // idle length: mostly none, some short, a few long
   function automatic int pick_idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ranges lean on zero, full scale and short distances now and then
   function automatic logic [RANGE_W-1:0] pick_range();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2:       return RANGE_W'($urandom_range(1, 255));
         default: return RANGE_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // mismatch reporting
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      // keep the log short on a badly broken build, but count every one
      if (mismatch_count < MAX_REPORTS) begin
         $display("[%0t] point %0d: %s got %0d, expected %0d",
                  $realtime, points_checked, what, got, want);
      end
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------

   // one sample transfer; valid stays high so back-to-back samples need no gap
   task automatic send_sample(input logic [BEAM_W-1:0] beam,
                              input logic [RANGE_W-1:0] range_val);
      int gap;
      gap = sender_steady ? 0 : pick_idle_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.beam_index   <= beam;
      req_if.range_sample <= range_val;
      do @(posedge clock); while (!req_if.ready);
      // transfer taken: the expectation is queued at the same edge
      expected_points.push_back(predict_point(beam, range_val));
      samples_sent++;
   endtask

   // drop valid, let every owed point come out, then let the pipe settle
   task automatic wait_pipe_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_pipe_idle();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      // mirror the write; indexes without a register are dropped
      case (idx)
         CSR_START_ANGLE: start_angle_q = value;
         CSR_ANGLE_STEP:  angle_step_q  = value;
         default: ;
      endcase
      register_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // receiver: ready drops for random stretches unless running steady
   initial begin : point_receiver
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!receiver_steady) stall_left = pick_idle_cycles();
         end
      end
   end

   // ---------------------------------------------------------------
   // result check: each rsp transfer against the oldest expectation
   // ---------------------------------------------------------------

   always @(posedge clock) begin : point_check
      point_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("point with no sample behind it, x", rsp_if.point_x, 0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_if.point_x !== want.x) report_mismatch("point_x", rsp_if.point_x, want.x);
            if (rsp_if.point_y !== want.y) report_mismatch("point_y", rsp_if.point_y, want.y);
         end
         points_checked++;
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped by watchdog after %0d cycles, %0d points still owed",
                  cycle_count, expected_points.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // both registers reset to zero, so every beam points along +x
   task automatic test_reset_defaults();
      send_sample(12'd0, 16'd0);
      send_sample(12'd4095, 16'hFFFF);
      send_sample(12'hAAA, 16'h5555);
   endtask

   // sixteenth-turn steps walk all quadrants, the octant fold points and the
   // wrap back to zero; then rounding of tiny and zero ranges
   task automatic test_quadrant_sweep();
      write_register(CSR_START_ANGLE, 16'd0);
      write_register(CSR_ANGLE_STEP, 16'd4096);
      for (int i = 0; i <= 16; i++) send_sample(BEAM_W'(i), 16'hFFFF);
      send_sample(12'd3, 16'd1);
      send_sample(12'd5, 16'd0);
   endtask

   // writes to indexes with no register behind them must change nothing
   task automatic test_spare_registers();
      write_register(CSR_SPARE_A, 16'hFFFF);
      write_register(CSR_SPARE_B, 16'h1234);
      send_sample(12'd1, 16'hFFFF);
      send_sample(12'd4095, 16'h8001);
   endtask

   // runs of consecutive beams under several register settings, with some
   // out-of-order beams mixed in; the first phases pin the extremes
   task automatic test_random_scans();
      logic [ANGLE_W-1:0] start_val;
      logic [ANGLE_W-1:0] step_val;
      logic [BEAM_W-1:0]  beam;
      for (int phase = 0; phase < SCAN_PHASES; phase++) begin
         case (phase)
            0: begin start_val = '0; step_val = '0; end
            1: begin start_val = '1; step_val = '1; end
            2: begin start_val = '0; step_val = 16'd1; end
            3: begin start_val = '1; step_val = '0; end
            default: begin
               start_val = ANGLE_W'($urandom);
               step_val  = ANGLE_W'($urandom);
            end
         endcase
         write_register(CSR_START_ANGLE, start_val);
         write_register(CSR_ANGLE_STEP, step_val);
         // some phases run with no idling on one side or both
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         beam = BEAM_W'($urandom);
         repeat (BEAMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) beam = BEAM_W'($urandom);
            send_sample(beam, pick_range());
            beam = beam + 1'b1;
         end
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      // every block input known from time zero
      req_if.valid        <= 1'b0;
      req_if.beam_index   <= '0;
      req_if.range_sample <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;
      start_angle_q = '0;
      angle_step_q  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_quadrant_sweep();
      test_spare_registers();
      test_random_scans();

      // drain what is left, then give a stray point time to show up
      wait_pipe_idle();

      $display("covered %0d beam samples, %0d points compared, %0d register writes",
               samples_sent, points_checked, register_writes);
      $display("quadrant sweep, spare register writes and %0d scan phases; %0d mismatches",
               SCAN_PHASES, mismatch_count);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
